FILE: hw/rtl/ctf_pkg.sv
package ctf_pkg;

  // iteration counts, queue depth and counter widths
  localparam int CordicSteps = 16;
  localparam int CordicIters = (CordicSteps < 32) ? CordicSteps : 32;
  localparam int CordicCntW  = $clog2(CordicIters);
  localparam int SqrtSteps   = 24;
  localparam int SqrtCntW    = $clog2(SqrtSteps + 1);
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  // angle and scale constants
  localparam logic signed [34:0] Deg180Q24 = 35'sd3019898880;
  localparam logic signed [25:0] Deg180Q15 = 26'sd5898240;
  localparam logic signed [30:0] RadQ24    = 31'sd961263669;

  // register reset values and indexes
  localparam logic [15:0] GyroWeightRst   = 16'd58982;
  localparam logic [15:0] SamplePeriodRst = 16'd655;
  localparam logic        CfgGyroWeight   = 1'b0;
  localparam logic        CfgSamplePeriod = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] roll_angle;
    logic signed [23:0] pitch_angle;
    logic               was_first;
  } out_item_t;

  typedef struct packed {
    logic signed [24:0] roll_y;
    logic signed [24:0] roll_x;
    logic signed [24:0] pitch_y;
    logic [30:0]        ysq;
    logic [30:0]        zsq;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } entry_t;

  typedef struct packed {
    logic [15:0] gyro_weight;
    logic [15:0] sample_period;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [24:0] y;
    logic signed [24:0] x;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [25:0] angle;
  } cordic_rsp_t;

  // arctangent of 2^-i in Q.24 degrees
  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489088;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000934;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754917;
      5'd9:  r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      5'd24: r = 30'd57;
      5'd25: r = 30'd29;
      5'd26: r = 30'd14;
      5'd27: r = 30'd7;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      5'd31: r = 30'd0;
    endcase
    return r;
  endfunction

  // saturate to the q9.15 range
  function automatic logic signed [23:0] clamp_ang(input logic signed [29:0] v);
    logic signed [23:0] r;
    if (v > 30'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ctf_front.sv
module ctf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ctf_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  output logic              push_valid_o,
  output ctf_pkg::entry_t   push_data_o,
  input  logic              push_ready_i
);

  logic            valid_q;
  ctf_pkg::entry_t entry_q, entry_d;
  logic            accept;

  logic signed [24:0] ax25, ay25, az25;
  logic signed [31:0] ay32, az32, ysq32, zsq32;

  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    ax25  = {{9{in_data_i.accel_x[15]}}, in_data_i.accel_x};
    ay25  = {{9{in_data_i.accel_y[15]}}, in_data_i.accel_y};
    az25  = {{9{in_data_i.accel_z[15]}}, in_data_i.accel_z};
    ay32  = {{16{in_data_i.accel_y[15]}}, in_data_i.accel_y};
    az32  = {{16{in_data_i.accel_z[15]}}, in_data_i.accel_z};
    ysq32 = ay32 * ay32;
    zsq32 = az32 * az32;
    // roll works on (ay, -az), pitch on (-ax * 256, magnitude)
    entry_d.roll_y  = ay25;
    entry_d.roll_x  = -az25;
    entry_d.pitch_y = -(ax25 <<< 8);
    entry_d.ysq     = ysq32[30:0];
    entry_d.zsq     = zsq32[30:0];
    entry_d.gyro_x  = in_data_i.gyro_x;
    entry_d.gyro_y  = in_data_i.gyro_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = entry_q;

endmodule

FILE: hw/rtl/ctf_queue.sv
module ctf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ctf_pkg::entry_t push_data_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ctf_pkg::entry_t pop_data_o,
  input  logic            pop_ready_i
);

  ctf_pkg::entry_t                 mem_q [ctf_pkg::QDepth];
  logic [ctf_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ctf_pkg::QCntW-1:0]       count_q;
  logic                            push, pop;

  assign push_ready_o = count_q != ctf_pkg::QCntW'(ctf_pkg::QDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == ctf_pkg::QPtrW'(ctf_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == ctf_pkg::QPtrW'(ctf_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ctf_pkg::QCntW'(ctf_pkg::QDepth))
    else $error("queue count above depth");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count not lowered on pop");
`endif

endmodule

FILE: hw/rtl/ctf_cordic.sv
module ctf_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctf_pkg::cordic_req_t req_i,
  output ctf_pkg::cordic_rsp_t rsp_o
);

  logic                            busy_q, done_q;
  logic [ctf_pkg::CordicCntW-1:0]  cnt_q;
  logic signed [43:0]              x_q, y_q, xn, yn, dx, dy;
  logic signed [34:0]              acc_q, an, atan, rnd, acc0;
  logic signed [25:0]              angle_q;
  logic [4:0]                      idx;
  logic                            last, neg, zero_y, zero_x;
  logic signed [25:0]              ys26, xs26, ya, xa;

  always_comb begin
    idx  = 5'(cnt_q);
    dx   = y_q >>> idx;
    dy   = x_q >>> idx;
    atan = {5'b0, ctf_pkg::atan_q24(idx)};
    if (!y_q[43]) begin
      xn = x_q + dx;
      yn = y_q - dy;
      an = acc_q + atan;
    end else begin
      xn = x_q - dx;
      yn = y_q + dy;
      an = acc_q - atan;
    end
    last = cnt_q == ctf_pkg::CordicCntW'(ctf_pkg::CordicIters - 1);
    rnd  = an + 35'sd256;

    // left half plane: turn by 180 degrees first
    zero_y = req_i.y == '0;
    zero_x = req_i.x == '0;
    neg    = req_i.x[24];
    ys26   = {req_i.y[24], req_i.y};
    xs26   = {req_i.x[24], req_i.x};
    ya     = neg ? -ys26 : ys26;
    xa     = neg ? -xs26 : xs26;
    if (!neg) begin
      acc0 = '0;
    end else if (!req_i.y[24]) begin
      acc0 = ctf_pkg::Deg180Q24;
    end else begin
      acc0 = -ctf_pkg::Deg180Q24;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if (zero_y) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= {{2{xa[25]}}, xa, 16'b0};
      y_q   <= {{2{ya[25]}}, ya, 16'b0};
      acc_q <= acc0;
      // zero y: angle is 0 or 180 without iterating
      if (zero_x || !neg) begin
        angle_q <= '0;
      end else begin
        angle_q <= ctf_pkg::Deg180Q15;
      end
    end else if (busy_q) begin
      x_q   <= xn;
      y_q   <= yn;
      acc_q <= an;
      if (last) begin
        angle_q <= rnd[34:9];
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("cordic started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q && !busy_q)
    else $error("cordic done not a single pulse");
`endif

endmodule

FILE: hw/rtl/ctf_back.sv
module ctf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  input  ctf_pkg::entry_t      pop_data_i,
  output logic                 pop_ready_o,
  input  ctf_pkg::cfg_t        cfg_i,
  output ctf_pkg::cordic_req_t req_o,
  input  ctf_pkg::cordic_rsp_t rsp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ctf_pkg::out_item_t   out_data_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRoll  = 8'b0000_0010,
    StPitch = 8'b0000_0100,
    StMul1  = 8'b0000_1000,
    StMul2  = 8'b0001_0000,
    StPred  = 8'b0010_0000,
    StMul3  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic                         start_q, start_d, roll_ok_q, primed_q, out_valid_q;
  logic [ctf_pkg::SqrtCntW-1:0] sq_cnt_q;
  logic                         sqrt_fin, out_free, roll_go;
  logic [47:0]                  v_q;
  logic [27:0]                  r_q, r2, t;
  logic [23:0]                  q_q;
  logic signed [24:0]           op_y_q, op_x_q, pitch_y_q;
  logic signed [15:0]           gx_q, gy_q;
  logic signed [25:0]           meas_r_q, meas_p_q;
  logic signed [16:0]           sp17;
  logic signed [17:0]           w18, cw18;
  logic signed [31:0]           prod_r_q, prod_p_q;
  logic signed [62:0]           inc_r_q, inc_p_q, inc_rnd_r, inc_rnd_p;
  logic signed [27:0]           pred_r_q, pred_p_q;
  logic signed [45:0]           s1r_q, s2r_q, s1p_q, s2p_q, sum_r, sum_p;
  logic signed [23:0]           roll_st_q, pitch_st_q, roll_new, pitch_new;
  ctf_pkg::out_item_t           out_data_q;
  logic [31:0]                  sq_sum;

  assign sqrt_fin    = sq_cnt_q == ctf_pkg::SqrtCntW'(ctf_pkg::SqrtSteps);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_ready_o = state_q == StIdle;
  assign roll_go     = sqrt_fin && (roll_ok_q || rsp_i.done);
  assign sq_sum      = {1'b0, pop_data_i.ysq} + {1'b0, pop_data_i.zsq};

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          state_d = StRoll;
          start_d = 1'b1;
        end
      end
      StRoll: begin
        if (roll_go) begin
          state_d = StPitch;
          start_d = 1'b1;
        end
      end
      StPitch: begin
        if (rsp_i.done) begin
          state_d = primed_q ? StMul1 : StOut;
        end
      end
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StPred;
      StPred:  state_d = StMul3;
      StMul3:  state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    r2        = {r_q[25:0], v_q[47:46]};
    t         = {2'b00, q_q, 2'b01};
    sp17      = {1'b0, cfg_i.sample_period};
    w18       = {2'b00, cfg_i.gyro_weight};
    cw18      = 18'sd65536 - w18;
    inc_rnd_r = inc_r_q + 63'sd34359738368;
    inc_rnd_p = inc_p_q + 63'sd34359738368;
    sum_r     = s1r_q + s2r_q + 46'sd32768;
    sum_p     = s1p_q + s2p_q + 46'sd32768;
    if (primed_q) begin
      roll_new  = ctf_pkg::clamp_ang(sum_r[45:16]);
      pitch_new = ctf_pkg::clamp_ang(sum_p[45:16]);
    end else begin
      roll_new  = ctf_pkg::clamp_ang({{4{meas_r_q[25]}}, meas_r_q});
      pitch_new = ctf_pkg::clamp_ang({{4{meas_p_q[25]}}, meas_p_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= 1'b0;
      roll_ok_q   <= 1'b0;
      sq_cnt_q    <= '0;
      primed_q    <= 1'b0;
      roll_st_q   <= '0;
      pitch_st_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      if (state_q == StIdle && pop_valid_i) begin
        roll_ok_q <= 1'b0;
        sq_cnt_q  <= '0;
      end
      if (state_q == StRoll) begin
        if (!sqrt_fin) begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
        end
        if (rsp_i.done) begin
          roll_ok_q <= 1'b1;
        end
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
        roll_st_q   <= roll_new;
        pitch_st_q  <= pitch_new;
        primed_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          gx_q      <= pop_data_i.gyro_x;
          gy_q      <= pop_data_i.gyro_y;
          pitch_y_q <= pop_data_i.pitch_y;
          op_y_q    <= pop_data_i.roll_y;
          op_x_q    <= pop_data_i.roll_x;
          v_q       <= {sq_sum, 16'b0};
          r_q       <= '0;
          q_q       <= '0;
        end
      end
      StRoll: begin
        // one root bit per cycle in the roll state, beside the roll angle
        if (!sqrt_fin) begin
          v_q <= {v_q[45:0], 2'b00};
          if (r2 >= t) begin
            r_q <= r2 - t;
            q_q <= {q_q[22:0], 1'b1};
          end else begin
            r_q <= r2;
            q_q <= {q_q[22:0], 1'b0};
          end
        end
        if (rsp_i.done) begin
          meas_r_q <= rsp_i.angle;
        end
        if (roll_go) begin
          op_y_q <= pitch_y_q;
          op_x_q <= {1'b0, q_q};
        end
      end
      StPitch: begin
        if (rsp_i.done) begin
          meas_p_q <= rsp_i.angle;
        end
      end
      StMul1: begin
        prod_r_q <= gx_q * sp17;
        prod_p_q <= gy_q * sp17;
      end
      StMul2: begin
        inc_r_q <= prod_r_q * ctf_pkg::RadQ24;
        inc_p_q <= prod_p_q * ctf_pkg::RadQ24;
      end
      StPred: begin
        pred_r_q <= {{4{roll_st_q[23]}}, roll_st_q} + {inc_rnd_r[62], inc_rnd_r[62:36]};
        pred_p_q <= {{4{pitch_st_q[23]}}, pitch_st_q} + {inc_rnd_p[62], inc_rnd_p[62:36]};
      end
      StMul3: begin
        s1r_q <= pred_r_q * w18;
        s2r_q <= meas_r_q * cw18;
        s1p_q <= pred_p_q * w18;
        s2p_q <= meas_p_q * cw18;
      end
      StOut: begin
        if (out_free) begin
          out_data_q.roll_angle  <= roll_new;
          out_data_q.pitch_angle <= pitch_new;
          out_data_q.was_first   <= !primed_q;
        end
      end
      default: ;
    endcase
  end

  assign req_o.start = start_q;
  assign req_o.y     = op_y_q;
  assign req_o.x     = op_x_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/complementary_tilt_filter.sv
// back end: square root beside the roll angle, pitch on the shared cordic, then the blend
//   (skipped on the first sample); it takes the next transaction only when back to idle,
//   and the queue holds transactions meanwhile
// reset: filtered angles clear to zero, the next sample loads the accelerometer
//   angles directly, blend weight and sample period return to 0.9 and 0.01 s
module complementary_tilt_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ctf_pkg::in_item_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctf_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               cfg_ready_o
);

  // configuration registers, always writable
  ctf_pkg::cfg_t cfg_q;

  // front to queue to back
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  ctf_pkg::entry_t      push_data, pop_data;
  ctf_pkg::cordic_req_t cordic_req;
  ctf_pkg::cordic_rsp_t cordic_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_weight   <= ctf_pkg::GyroWeightRst;
      cfg_q.sample_period <= ctf_pkg::SamplePeriodRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ctf_pkg::CfgGyroWeight:   cfg_q.gyro_weight   <= cfg_data_i;
        ctf_pkg::CfgSamplePeriod: cfg_q.sample_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: registers the sample, forms squares and cordic operands
  ctf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // short queue so the front keeps taking transactions while the back works
  ctf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // back: square root, angle sequencing, blend and output register
  ctf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_q),
    .req_o       (cordic_req),
    .rsp_i       (cordic_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // shared vectoring cordic, one iteration per cycle
  ctf_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

endmodule
